### design/delimited_token_splitter_defines.svh
// ----------------------------------------------------------------------------
// delimited_token_splitter_defines
// assertion macros shared by the token splitter modules
// ----------------------------------------------------------------------------
`ifndef DELIMITED_TOKEN_SPLITTER_DEFINES_SVH
`define DELIMITED_TOKEN_SPLITTER_DEFINES_SVH

`ifndef SYNTH

// checked only outside reset, clocked by clk
`define DTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define DTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define DTS_ASSERT(lbl, prop)
`define DTS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### design/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// types, codes and helpers of the delimited token splitter
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int MAX_TOKEN_LEN = 256;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // character codes
  localparam logic [7:0] CH_EOT    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_WS_MAX = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // token kinds
  localparam logic [1:0] KIND_BARE    = 2'd0;
  localparam logic [1:0] KIND_QUOTED  = 2'd1;
  localparam logic [1:0] KIND_PAREN   = 2'd2;
  localparam logic [1:0] KIND_BRACKET = 2'd3;

  // status codes
  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_UNTERM  = 2'd2;
  localparam logic [1:0] ST_EOT     = 2'd3;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       char_valid;
    logic       token_end;
    logic [1:0] token_kind;
    logic [1:0] status;
  } res_t;

  function automatic res_t mk_char(input logic [7:0] b, input logic [1:0] kind);
    res_t r;
    r.token_byte = b;
    r.char_valid = 1'b1;
    r.token_end  = 1'b0;
    r.token_kind = kind;
    r.status     = ST_NORMAL;
    return r;
  endfunction

  function automatic res_t mk_end(input logic [1:0] kind, input logic [1:0] st);
    res_t r;
    r.token_byte = CH_EOT;
    r.char_valid = 1'b0;
    r.token_end  = 1'b1;
    r.token_kind = kind;
    r.status     = st;
    return r;
  endfunction

  function automatic res_t mk_eot();
    res_t r;
    r.token_byte = CH_EOT;
    r.char_valid = 1'b0;
    r.token_end  = 1'b0;
    r.token_kind = KIND_BARE;
    r.status     = ST_EOT;
    return r;
  endfunction

endpackage

### design/delimited_token_splitter.sv
// results: the results of an accepted byte are registered in the result queue
// throughput: one text byte per cycle while the result queue has room; the
//   result port moves one beat a cycle while out_tready is high, so bytes
//   yielding two results (e.g. token end, end of text) fill the 4-entry queue
// reset: synchronous, active low; the scanner returns to idle and the queue
//   empties at once
// ----------------------------------------------------------------------------
// delimited_token_splitter
// streaming text tokenizer: splits bytes into bare and delimited tokens
// ----------------------------------------------------------------------------
module delimited_token_splitter
  import dts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_byte
  output logic [4:0] out_tuser,  // [0] char_valid, [2:1] token_kind, [4:3] status
  output logic       out_tlast   // token_end
);

  logic       step;
  logic       room;
  res_t       res0;
  res_t       res1;
  logic [1:0] res_n;
  logic [1:0] push_n;
  res_t       head;

  assign in_tready = room;
  assign step      = in_tvalid && room;
  assign push_n    = step ? res_n : 2'd0;

  dts_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .text_byte (in_tdata),
    .res0      (res0),
    .res1      (res1),
    .res_n     (res_n)
  );

  dts_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = head.token_byte;
  assign out_tuser = {head.status, head.token_kind, head.char_valid};
  assign out_tlast = head.token_end;

endmodule

### design/dts_scan.sv
// ----------------------------------------------------------------------------
// dts_scan
// scanner state and the per-byte step: up to two results per text byte
// ----------------------------------------------------------------------------
`include "delimited_token_splitter_defines.svh"

module dts_scan
  import dts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  text_byte,
  output res_t        res0,
  output res_t        res1,
  output logic [1:0]  res_n
);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_SLASH   = 3'd1;
  localparam logic [2:0] M_COMMENT = 3'd2;
  localparam logic [2:0] M_QUOTED  = 3'd3;
  localparam logic [2:0] M_PAREN   = 3'd4;
  localparam logic [2:0] M_BRACKET = 3'd5;
  localparam logic [2:0] M_BARE    = 3'd6;

  logic [2:0]       mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;

  logic [2:0] op_mode;
  logic       is_op;
  logic       is_ws;
  logic       room;
  logic [1:0] st_close;
  logic [1:0] cur_kind;
  logic [7:0] closer;

  always_comb begin
    case (text_byte)
      CH_QUOTE:  op_mode = M_QUOTED;
      CH_LPAREN: op_mode = M_PAREN;
      CH_LBRACK: op_mode = M_BRACKET;
      default:   op_mode = M_IDLE;
    endcase
    case (mode_r)
      M_QUOTED: begin
        cur_kind = KIND_QUOTED;
        closer   = CH_QUOTE;
      end
      M_PAREN: begin
        cur_kind = KIND_PAREN;
        closer   = CH_RPAREN;
      end
      M_BRACKET: begin
        cur_kind = KIND_BRACKET;
        closer   = CH_RBRACK;
      end
      default: begin
        cur_kind = KIND_BARE;
        closer   = CH_EOT;
      end
    endcase
  end

  assign is_op    = (op_mode != M_IDLE);
  assign is_ws    = (text_byte != CH_EOT) && (text_byte <= CH_WS_MAX);
  assign room     = (len_r < LEN_W'(MAX_TOKEN_LEN));
  assign st_close = ovf_r ? ST_TRUNC : ST_NORMAL;

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    res0     = '0;
    res1     = '0;
    res_n    = 2'd0;
    case (mode_r)
      M_SLASH: begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
        if (text_byte == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else if (text_byte == CH_EOT) begin
          res0     = mk_char(CH_SLASH, KIND_BARE);
          res0.token_end = 1'b1;
          res1     = mk_eot();
          res_n    = 2'd2;
          mode_nxt = M_IDLE;
        end else if (is_ws || is_op) begin
          res0     = mk_char(CH_SLASH, KIND_BARE);
          res0.token_end = 1'b1;
          res_n    = 2'd1;
          mode_nxt = op_mode;
        end else begin
          // the slash opens a bare token together with this byte
          res0     = mk_char(CH_SLASH, KIND_BARE);
          res1     = mk_char(text_byte, KIND_BARE);
          res_n    = 2'd2;
          mode_nxt = M_BARE;
          len_nxt  = LEN_W'(2);
        end
      end
      M_COMMENT: begin
        if (text_byte == CH_NL) begin
          mode_nxt = M_IDLE;
        end else if (text_byte == CH_EOT) begin
          res0     = mk_eot();
          res_n    = 2'd1;
          mode_nxt = M_IDLE;
        end
      end
      M_QUOTED, M_PAREN, M_BRACKET: begin
        if (text_byte == closer) begin
          res0     = mk_end(cur_kind, st_close);
          res_n    = 2'd1;
          mode_nxt = M_IDLE;
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
        end else if (text_byte == CH_EOT) begin
          res0     = mk_end(cur_kind, ST_UNTERM);
          res1     = mk_eot();
          res_n    = 2'd2;
          mode_nxt = M_IDLE;
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
        end else if (room) begin
          res0    = mk_char(text_byte, cur_kind);
          res_n   = 2'd1;
          len_nxt = len_r + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      M_BARE: begin
        if (text_byte == CH_EOT) begin
          res0     = mk_end(KIND_BARE, st_close);
          res1     = mk_eot();
          res_n    = 2'd2;
          mode_nxt = M_IDLE;
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
        end else if (is_ws || is_op) begin
          res0     = mk_end(KIND_BARE, st_close);
          res_n    = 2'd1;
          mode_nxt = op_mode;
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
        end else if (room) begin
          res0    = mk_char(text_byte, KIND_BARE);
          res_n   = 2'd1;
          len_nxt = len_r + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      default: begin
        // idle, and the unused mode code
        len_nxt = '0;
        ovf_nxt = 1'b0;
        if (text_byte == CH_EOT) begin
          res0     = mk_eot();
          res_n    = 2'd1;
          mode_nxt = M_IDLE;
        end else if (is_ws) begin
          mode_nxt = M_IDLE;
        end else if (text_byte == CH_SLASH) begin
          mode_nxt = M_SLASH;
        end else if (is_op) begin
          mode_nxt = op_mode;
        end else begin
          res0     = mk_char(text_byte, KIND_BARE);
          res_n    = 2'd1;
          mode_nxt = M_BARE;
          len_nxt  = LEN_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      len_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  `DTS_ASSERT(a_len_bound, len_r <= LEN_W'(MAX_TOKEN_LEN))
  `DTS_ASSERT(a_ovf_full, ovf_r |-> len_r == LEN_W'(MAX_TOKEN_LEN))
  `DTS_ASSERT(a_no_token_clear,
    (mode_r == M_IDLE || mode_r == M_SLASH || mode_r == M_COMMENT) |->
    (len_r == '0 && !ovf_r))

endmodule

### design/dts_rq.sv
// ----------------------------------------------------------------------------
// dts_rq
// small result queue: takes up to two results per cycle, hands out one beat
// ----------------------------------------------------------------------------
`include "delimited_token_splitter_defines.svh"

module dts_rq
  import dts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push0,
  input  res_t       push1,
  output logic       room,
  output logic       head_valid,
  output res_t       head,
  input  logic       pop
);

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QPTR_W-1:0] wr1;
  logic              do_pop;

  // two free entries are needed for the worst-case byte
  assign room       = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_r];
  assign do_pop     = pop && head_valid;
  assign wr1        = wr_r + QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_r] <= push0;
    if (push_n == 2'd2) q_r[wr1]  <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QPTR_W'(push_n);
      rd_r  <= rd_r + QPTR_W'(do_pop);
      cnt_r <= cnt_r + QCNT_W'(push_n) - QCNT_W'(do_pop);
    end
  end

  `DTS_ASSERT(a_cnt_bound, cnt_r <= QCNT_W'(QDEPTH))
  `DTS_ASSERT(a_push_room, (push_n != 2'd0) |-> room)
  `DTS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> cnt_r == '0)

endmodule

### tb/delimited_token_splitter_test.sv
// ----------------------------------------------------------------------------
// delimited_token_splitter_test
// drives text bytes into the token splitter and predicts every result beat
// (token characters, token end markers and end-of-text beats) with its own
// scanner model; directed texts cover the token kinds, slash and comment
// handling, unterminated and truncated tokens, then random texts follow
// ----------------------------------------------------------------------------
module delimited_token_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dts_pkg::*;

  // about 1350 bytes in all; the limit allows for input gaps before each byte
  // and for receiver stalls on every result beat
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SLASH,
    SCAN_COMMENT,
    SCAN_QUOTED,
    SCAN_PAREN,
    SCAN_BRACKET,
    SCAN_BARE
  } scan_e;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [4:0] out_tuser;
  logic       out_tlast;

  // tokenizer state as the testbench sees it
  scan_e       scan_state  = SCAN_IDLE;
  int unsigned tok_len     = 0;
  bit          tok_dropped = 1'b0;
  res_t        pending_beats[$];

  int          error_count = 0;
  int          cycle_count = 0;
  int unsigned sent_bytes  = 0;
  bit          in_gaps_on  = 1'b0;
  bit          out_gaps_on = 1'b0;
  int          stall_left  = 0;

  delimited_token_splitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_beat(logic [7:0] b, logic cv, logic last,
                                    logic [1:0] kind, logic [1:0] st);
    res_t r;
    r.token_byte = b;
    r.char_valid = cv;
    r.token_end  = last;
    r.token_kind = kind;
    r.status     = st;
    pending_beats.push_back(r);
  endfunction

  function automatic void push_end_of_text();
    push_beat(8'h00, 1'b0, 1'b0, KIND_BARE, ST_EOT);
  endfunction

  function automatic void open_token(scan_e m);
    scan_state  = m;
    tok_len     = 0;
    tok_dropped = 1'b0;
  endfunction

  function automatic void token_char(logic [7:0] b, logic [1:0] kind);
    if (tok_len < MAX_TOKEN_LEN) begin
      tok_len++;
      push_beat(b, 1'b1, 1'b0, kind, ST_NORMAL);
    end else begin
      tok_dropped = 1'b1;
    end
  endfunction

  function automatic scan_e opener_scan(logic [7:0] b);
    case (b)
      CH_QUOTE:  return SCAN_QUOTED;
      CH_LPAREN: return SCAN_PAREN;
      CH_LBRACK: return SCAN_BRACKET;
      default:   return SCAN_IDLE;
    endcase
  endfunction

  function automatic void predict_text_byte(logic [7:0] b);
    logic [1:0] kind;
    logic [7:0] closer;
    logic [1:0] st;
    st = tok_dropped ? ST_TRUNC : ST_NORMAL;
    case (scan_state)
      SCAN_SLASH: begin
        if (b == CH_SLASH) begin
          scan_state = SCAN_COMMENT;
        end else if (b > CH_WS_MAX && opener_scan(b) == SCAN_IDLE) begin
          open_token(SCAN_BARE);
          token_char(CH_SLASH, KIND_BARE);
          token_char(b, KIND_BARE);
        end else begin
          // lone slash is a one-character bare token
          push_beat(CH_SLASH, 1'b1, 1'b1, KIND_BARE, ST_NORMAL);
          if (b == CH_EOT) push_end_of_text();
          open_token(opener_scan(b));
        end
      end
      SCAN_COMMENT: begin
        if (b == CH_NL) begin
          open_token(SCAN_IDLE);
        end else if (b == CH_EOT) begin
          push_end_of_text();
          open_token(SCAN_IDLE);
        end
      end
      SCAN_QUOTED, SCAN_PAREN, SCAN_BRACKET: begin
        kind   = (scan_state == SCAN_QUOTED) ? KIND_QUOTED :
                 (scan_state == SCAN_PAREN)  ? KIND_PAREN  : KIND_BRACKET;
        closer = (scan_state == SCAN_QUOTED) ? CH_QUOTE :
                 (scan_state == SCAN_PAREN)  ? CH_RPAREN : CH_RBRACK;
        if (b == closer) begin
          push_beat(8'h00, 1'b0, 1'b1, kind, st);
          open_token(SCAN_IDLE);
        end else if (b == CH_EOT) begin
          // unterminated wins over truncated
          push_beat(8'h00, 1'b0, 1'b1, kind, ST_UNTERM);
          push_end_of_text();
          open_token(SCAN_IDLE);
        end else begin
          token_char(b, kind);
        end
      end
      SCAN_BARE: begin
        if (b <= CH_WS_MAX || opener_scan(b) != SCAN_IDLE) begin
          push_beat(8'h00, 1'b0, 1'b1, KIND_BARE, st);
          if (b == CH_EOT) push_end_of_text();
          open_token(opener_scan(b));
        end else begin
          token_char(b, KIND_BARE);
        end
      end
      default: begin
        if (b == CH_EOT) push_end_of_text();
        if (b <= CH_WS_MAX) begin
          open_token(SCAN_IDLE);
        end else if (b == CH_SLASH) begin
          open_token(SCAN_SLASH);
        end else if (opener_scan(b) != SCAN_IDLE) begin
          open_token(opener_scan(b));
        end else begin
          open_token(SCAN_BARE);
          token_char(b, KIND_BARE);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("delimited_token_splitter_test: FAIL");
      $finish;
    end else begin
      if (rst_n && in_tvalid && in_tready) predict_text_byte(in_tdata);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_beats.size() == 0) begin
          $error("result beat with nothing pending: tdata 0x%0h tuser 0x%0h tlast %0b",
                 out_tdata, out_tuser, out_tlast);
          error_count++;
        end else begin
          want = pending_beats.pop_front();
          check_field("token_byte", want.token_byte, out_tdata);
          check_field("char_valid", 8'(want.char_valid), 8'(out_tuser[0]));
          check_field("token_kind", 8'(want.token_kind), 8'(out_tuser[2:1]));
          check_field("status", 8'(want.status), 8'(out_tuser[4:3]));
          check_field("token_end", 8'(want.token_end), 8'(out_tlast));
        end
      end
    end
  end

  // receiver stalls in random bursts while out_gaps_on is set
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sender

  // called at a falling edge, returns at the falling edge after the beat moved
  task automatic send_byte(input logic [7:0] b);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_bare_char();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 255));
    while (b == CH_QUOTE || b == CH_LPAREN || b == CH_LBRACK);
    return b;
  endfunction

  function automatic logic [7:0] rand_inner_char(logic [7:0] closer);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == closer);
    return b;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_token_kinds();
    send_text("ab");
    hold_until_drained();
    send_text("\"q r\"(p)[k]");
    send_byte(8'h01);
    send_byte(8'h21);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h20);
    send_text("\"\"()[]x");
    send_byte(CH_EOT);
    send_byte(CH_EOT);
  endtask

  task automatic test_slash_and_comments();
    send_text("/a / /(p)//c d\n/");
    send_byte(CH_EOT);
    send_text("//x");
    send_byte(CH_EOT);
    send_text("/[z]");
    send_byte(CH_EOT);
  endtask

  task automatic test_unterminated();
    send_text("\"ab");
    send_byte(CH_EOT);
    send_text("(");
    send_byte(CH_EOT);
    send_text("[x)");
    send_byte(CH_EOT);
    send_text("ab[");
    send_byte(CH_EOT);
  endtask

  task automatic test_truncation();
    // bare token of exactly the maximum length, closed by an opener
    send_byte("m");
    repeat (MAX_TOKEN_LEN - 1) send_byte(rand_bare_char());
    send_byte(CH_LPAREN);
    // over-long parenthesised token cut off by end of text
    repeat (MAX_TOKEN_LEN + 1) send_byte(rand_inner_char(CH_RPAREN));
    send_byte(CH_EOT);
    send_byte("n");
    repeat (MAX_TOKEN_LEN) send_byte(rand_bare_char());
    send_byte(8'h20);
    send_byte(CH_QUOTE);
    repeat (MAX_TOKEN_LEN + 2) send_byte(rand_inner_char(CH_QUOTE));
    send_byte(CH_QUOTE);
    send_byte(CH_EOT);
  endtask

  task automatic send_random_text();
    int         n_tokens;
    int         len;
    int         pick;
    logic [7:0] opener;
    logic [7:0] closer;
    n_tokens = $urandom_range(1, 6);
    repeat (n_tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        repeat ($urandom_range(0, 6)) send_byte(rand_inner_char(CH_NL));
        send_byte(($urandom_range(0, 9) == 0) ? CH_EOT : CH_NL);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 32)));
      end
      len  = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        send_byte(($urandom_range(0, 9) == 0) ? CH_SLASH : rand_bare_char());
        repeat (len) send_byte(rand_bare_char());
      end else begin
        if (pick < 65) begin
          opener = CH_QUOTE;
          closer = CH_QUOTE;
        end else if (pick < 83) begin
          opener = CH_LPAREN;
          closer = CH_RPAREN;
        end else begin
          opener = CH_LBRACK;
          closer = CH_RBRACK;
        end
        send_byte(opener);
        repeat (len) send_byte(rand_inner_char(closer));
        if ($urandom_range(0, 9) != 0) send_byte(closer);
      end
      if ($urandom_range(0, 49) == 0) hold_until_drained();
    end
    send_byte(CH_EOT);
  endtask

  task automatic test_random_text(input int unsigned n_bytes, input bit in_gaps,
                                  input bit out_gaps);
    int unsigned goal;
    goal        = sent_bytes + n_bytes;
    in_gaps_on  = in_gaps;
    out_gaps_on = out_gaps;
    while (sent_bytes < goal) send_random_text();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    test_token_kinds();
    test_slash_and_comments();
    test_unterminated();
    test_truncation();
    test_random_text(80, 1'b1, 1'b1);
    test_random_text(40, 1'b1, 1'b0);
    test_random_text(40, 1'b0, 1'b1);
    test_random_text(90, 1'b0, 1'b0);

    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("delimited_token_splitter_test: PASS");
    end else begin
      $display("delimited_token_splitter_test: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/dts_pkg.sv
design/dts_scan.sv
design/dts_rq.sv
design/delimited_token_splitter.sv
tb/delimited_token_splitter_test.sv
